/* rtl/fpalu_pkg.sv */
// Package: opcodes, status codes and defaults for the fixed-point ALU.
package fpalu_pkg;

  localparam int unsigned DefFractionBits = 8;
  localparam int unsigned DefWordBits     = 32;
  localparam int unsigned FieldBits       = 32;

  typedef enum logic [3:0] {
    OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
    OP_GT  = 4'd4, OP_LT  = 4'd5, OP_GE  = 4'd6, OP_LE  = 4'd7,
    OP_EQ  = 4'd8, OP_NE  = 4'd9, OP_MIN = 4'd10, OP_MAX = 4'd11,
    OP_INC = 4'd12, OP_DEC = 4'd13, OP_TOINT = 4'd14, OP_NONE = 4'd15
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_OVF  = 2'd1,
    ST_DIV0 = 2'd2,
    ST_RSVD = 2'd3
  } status_e;

endpackage

/* rtl/fixed_point_alu_top.sv */
// Fixed-point ALU: pipelined add/sub/mul/div/inc/dec, compare, min/max, to-int; saturating.
// Path from the accepting edge to done_o: s0, s1, s2, the divider stages, done_q (Q24.8 default).
// Throughput: one word per cycle; busy stays low, results cannot be stalled.
// Depth is set by the restoring divider, one quotient bit per stage.
// Reset: rst_ni asynchronous active low clears all stage valid bits.
// Multiplier is split across two stages of half-width partial products.
module fixed_point_alu_top
  import fpalu_pkg::*;
#(
  parameter int unsigned FractionBits = DefFractionBits,
  parameter int unsigned WordBits     = DefWordBits
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [3:0]           opcode_i,
  input  logic [FieldBits-1:0] operand_a_i,
  input  logic [FieldBits-1:0] operand_b_i,
  output logic                 done_o,
  output logic [FieldBits-1:0] result_value_o,
  output logic                 compare_true_o,
  output logic [1:0]           status_o
);

  localparam int unsigned W  = WordBits;
  localparam int unsigned F  = FractionBits;
  localparam int unsigned NB = W + F;        // dividend bits
  localparam int unsigned H  = (W + 1) / 2;  // partial product split
  localparam int unsigned PB = 2 * W;        // full magnitude product width

  // Walk-through per stage: s0 register inputs, s1 simple ops and split product,
  // s2 product sum and mul rounding, then NB divider steps, then quotient rounding and output.
  localparam int unsigned NS = NB;

  assign busy = 1'b0;

  // ---------------- stage 0: capture, sign-extend at word width ------------
  logic            v0_q;
  opcode_e         op0_q;
  logic [W-1:0]    a0_q, b0_q;
  logic [W-1:0]    a_in, b_in;

  always_comb begin
    // low W bits of the sign-extended field
    a_in = W'($signed(operand_a_i));
    b_in = W'($signed(operand_b_i));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else begin
      v0_q <= start;
    end
  end

  always_ff @(posedge clk_i) begin
    op0_q <= opcode_e'(opcode_i);
    a0_q  <= a_in;
    b0_q  <= b_in;
  end

  // ---------------- stage 1: simple ops, magnitudes, partial products ------
  localparam logic [W-1:0] MaxW = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MinW = {1'b1, {(W-1){1'b0}}};

  logic [W-1:0] simple_res;
  logic         simple_cmp;
  status_e      simple_st;
  logic         lt_ab, lt_ba, eq_ab;
  logic [W:0]   sum_x, dif_x;
  logic [W-1:0] ma, mb;
  logic         neg0;
  logic [H-1:0] ma_l, ma_h, mb_l, mb_h;

  always_comb begin
    lt_ab = $signed(a0_q) < $signed(b0_q);
    lt_ba = $signed(b0_q) < $signed(a0_q);
    eq_ab = a0_q == b0_q;
    sum_x = {a0_q[W-1], a0_q} + {b0_q[W-1], b0_q};
    dif_x = {a0_q[W-1], a0_q} - {b0_q[W-1], b0_q};
    simple_res = '0;
    simple_cmp = 1'b0;
    simple_st  = ST_OK;
    unique case (op0_q)
      OP_ADD: begin
        if (sum_x[W] != sum_x[W-1]) begin
          simple_st = ST_OVF; simple_res = sum_x[W] ? MinW : MaxW;
        end else simple_res = sum_x[W-1:0];
      end
      OP_SUB: begin
        if (dif_x[W] != dif_x[W-1]) begin
          simple_st = ST_OVF; simple_res = dif_x[W] ? MinW : MaxW;
        end else simple_res = dif_x[W-1:0];
      end
      OP_GT: simple_cmp = lt_ba;
      OP_LT: simple_cmp = lt_ab;
      OP_GE: simple_cmp = !lt_ab;
      OP_LE: simple_cmp = !lt_ba;
      OP_EQ: simple_cmp = eq_ab;
      OP_NE: simple_cmp = !eq_ab;
      OP_MIN: simple_res = lt_ab ? a0_q : b0_q;
      OP_MAX: simple_res = lt_ba ? a0_q : b0_q;
      OP_INC: begin
        if (a0_q == MaxW) begin simple_st = ST_OVF; simple_res = MaxW; end
        else simple_res = a0_q + W'(1);
      end
      OP_DEC: begin
        if (a0_q == MinW) begin simple_st = ST_OVF; simple_res = MinW; end
        else simple_res = a0_q - W'(1);
      end
      OP_TOINT: simple_res = W'($signed(a0_q) >>> F);
      default: ;
    endcase
    neg0 = a0_q[W-1] ^ b0_q[W-1];
    ma   = a0_q[W-1] ? (~a0_q + W'(1)) : a0_q;
    mb   = b0_q[W-1] ? (~b0_q + W'(1)) : b0_q;
    ma_l = ma[H-1:0];
    mb_l = mb[H-1:0];
    ma_h = H'(ma >> H);
    mb_h = H'(mb >> H);
  end

  logic            v1_q;
  opcode_e         op1_q;
  logic [W-1:0]    sres1_q, mb1_q, ma1_q;
  logic            scmp1_q, neg1_q;
  status_e         sst1_q;
  logic [2*H-1:0]  pll_q, plh_q, phl_q, phh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else v1_q <= v0_q;
  end

  always_ff @(posedge clk_i) begin
    op1_q   <= op0_q;
    sres1_q <= simple_res;
    scmp1_q <= simple_cmp;
    sst1_q  <= simple_st;
    neg1_q  <= neg0;
    ma1_q   <= ma;
    mb1_q   <= mb;
    pll_q   <= ma_l * mb_l;
    plh_q   <= ma_l * mb_h;
    phl_q   <= ma_h * mb_l;
    phh_q   <= ma_h * mb_h;
  end

  // ---------------- stage 2: product sum, mul rounding, divider setup ------
  logic [4*H-1:0] prod_full;
  logic [PB:0]    prod_rnd;
  logic [PB-F:0]  prod_q;

  always_comb begin
    prod_full = {{(2*H){1'b0}}, pll_q}
              + ({{(2*H){1'b0}}, plh_q} << H)
              + ({{(2*H){1'b0}}, phl_q} << H)
              + ({phh_q, {(2*H){1'b0}}});
    prod_rnd  = {1'b0, prod_full[PB-1:0]} + ((PB+1)'(1) << (F - 1));
    prod_q    = prod_rnd[PB:F];
  end

  // mul result held as magnitude, saturated at the end
  logic            v2_q;
  opcode_e         op2_q;
  logic [W-1:0]    sres2_q, mb2_q;
  logic            scmp2_q, neg2_q;
  status_e         sst2_q;
  logic [PB-F:0]   pmag2_q;
  logic [NB-1:0]   num2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else v2_q <= v1_q;
  end

  always_ff @(posedge clk_i) begin
    op2_q   <= op1_q;
    sres2_q <= sres1_q;
    scmp2_q <= scmp1_q;
    sst2_q  <= sst1_q;
    neg2_q  <= neg1_q;
    mb2_q   <= mb1_q;
    pmag2_q <= prod_q;
    num2_q  <= {ma1_q, {F{1'b0}}};
  end

  // ---------------- divider: one restoring step per stage ------------------
  // remainder kept one bit wider than the divisor so the shift never drops
  typedef struct packed {
    logic         v;
    opcode_e      op;
    logic [W-1:0] sres;
    logic         scmp;
    status_e      sst;
    logic         neg;
    logic [W-1:0] db;
    logic [PB-F:0] pmag;
    logic [NB-1:0] nq;   // numerator bits shift out, quotient bits shift in
    logic [W:0]   rem;
  } dstage_t;

  dstage_t ds_q [NS+1];

  always_comb begin
    ds_q[0].v    = v2_q;
    ds_q[0].op   = op2_q;
    ds_q[0].sres = sres2_q;
    ds_q[0].scmp = scmp2_q;
    ds_q[0].sst  = sst2_q;
    ds_q[0].neg  = neg2_q;
    ds_q[0].db   = mb2_q;
    ds_q[0].pmag = pmag2_q;
    ds_q[0].nq   = num2_q;
    ds_q[0].rem  = '0;
  end

  for (genvar g = 0; g < NS; g++) begin : g_div
    dstage_t    cur, nxt;
    logic [W:0] sh, sub;
    always_comb begin
      cur = ds_q[g];
      sh  = {cur.rem[W-1:0], cur.nq[NB-1]};
      sub = sh - {1'b0, cur.db};
      nxt = cur;
      if (!sub[W]) begin
        nxt.rem = sub;
        nxt.nq  = {cur.nq[NB-2:0], 1'b1};
      end else begin
        nxt.rem = sh;
        nxt.nq  = {cur.nq[NB-2:0], 1'b0};
      end
    end
    logic v_q;
    dstage_t pay_q;
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) v_q <= 1'b0;
      else v_q <= cur.v;
    end
    always_ff @(posedge clk_i) begin
      pay_q <= nxt;
    end
    always_comb begin
      ds_q[g+1]   = pay_q;
      ds_q[g+1].v = v_q;
    end
  end

  // ---------------- final stage: round quotient, saturate, select ----------
  dstage_t      fin;
  logic [W:0]   rem_d2;
  logic [NB:0]  quo;
  logic [NB:0]  mag_sel;
  logic [W-1:0] res_d;
  status_e      st_d;
  logic         cmp_d;
  logic [NB:0]  lim;

  always_comb begin
    fin    = ds_q[NS];
    // round half up on the magnitude: r >= d - r
    rem_d2 = {fin.rem[W-1:0], 1'b0};
    quo    = {1'b0, fin.nq} + (NB+1)'(rem_d2 >= {1'b0, fin.db});
    lim    = fin.neg ? (NB+1)'({1'b1, {(W-1){1'b0}}}) : (NB+1)'(MaxW);
    mag_sel = '0;
    res_d  = fin.sres;
    st_d   = fin.sst;
    cmp_d  = fin.scmp;
    if (fin.op == OP_MUL || fin.op == OP_DIV) begin
      mag_sel = (fin.op == OP_MUL) ? (NB+1)'(fin.pmag) : quo;
      if (fin.op == OP_MUL && (fin.pmag >> (NB + 1)) != '0) begin
        st_d  = ST_OVF;
        res_d = fin.neg ? MinW : MaxW;
      end else if (mag_sel > lim) begin
        st_d  = ST_OVF;
        res_d = fin.neg ? MinW : MaxW;
      end else begin
        st_d  = ST_OK;
        res_d = fin.neg ? (~mag_sel[W-1:0] + W'(1)) : mag_sel[W-1:0];
      end
      if (fin.op == OP_DIV && fin.db == '0) begin
        st_d  = ST_DIV0;
        res_d = '0;
      end
    end
  end

  logic         done_q;
  logic [W-1:0] res_q;
  logic         cmp_q;
  status_e      st_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else done_q <= fin.v;
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    cmp_q <= cmp_d;
    st_q  <= st_d;
  end

  assign done_o         = done_q;
  assign result_value_o = FieldBits'($signed(res_q));
  assign compare_true_o = cmp_q;
  assign status_o       = st_q;

`ifndef SYNTHESIS
  a_no_rsvd_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> status_o != ST_RSVD) else $error("reserved status");
  a_cmp_zero_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && compare_true_o |-> result_value_o == '0) else $error("compare with value");
  a_div0_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o == ST_DIV0 |-> result_value_o == '0 && !compare_true_o)
    else $error("div0 nonzero");
`endif

endmodule

/* bench/fixed_point_alu_checker.sv */
// Checker: predicts fixed-point ALU results and compares them on done_o.
module fixed_point_alu_checker
  import fpalu_pkg::*;
#(
  parameter int unsigned FractionBits = DefFractionBits
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  input  logic                 busy,
  input  logic [3:0]           opcode_i,
  input  logic [FieldBits-1:0] operand_a_i,
  input  logic [FieldBits-1:0] operand_b_i,
  input  logic                 done_o,
  input  logic [FieldBits-1:0] result_value_o,
  input  logic                 compare_true_o,
  input  logic [1:0]           status_o,
  output int                   fail_count,
  output int                   pending_count
);

  typedef struct packed {
    logic [31:0] value;
    logic        cmp;
    logic [1:0]  st;
  } alu_word_t;

  alu_word_t pending_q[$];

  localparam longint MaxW = 64'sh7FFFFFFF;
  localparam longint MinW = -64'sh80000000;

  // Saturate an exact signed value to 32 bits.
  function automatic alu_word_t sat_word(logic signed [127:0] v);
    alu_word_t w;
    w = '0;
    if (v > MaxW) begin
      w.value = 32'h7FFFFFFF; w.st = ST_OVF;
    end else if (v < MinW) begin
      w.value = 32'h80000000; w.st = ST_OVF;
    end else begin
      w.value = v[31:0]; w.st = ST_OK;
    end
    return w;
  endfunction

  function automatic alu_word_t alu_predict(logic [3:0] op, logic [31:0] ra, logic [31:0] rb);
    alu_word_t w;
    logic signed [127:0] a, b, n, q, r, ma, mb, mp;
    logic neg;
    w = '0;
    a = $signed(ra);
    b = $signed(rb);
    neg = a[127] ^ b[127];
    ma = a[127] ? -a : a;
    mb = b[127] ? -b : b;
    case (opcode_e'(op))
      OP_ADD: w = sat_word(a + b);
      OP_SUB: w = sat_word(a - b);
      OP_MUL: begin
        mp = (ma * mb + (128'sd1 <<< (FractionBits - 1))) >>> FractionBits;
        w = sat_word(neg ? -mp : mp);
      end
      OP_DIV: begin
        if (b == 0) begin
          w.st = ST_DIV0;
        end else begin
          n = ma <<< FractionBits;
          q = n / mb;
          r = n % mb;
          if (r >= mb - r) q = q + 1;
          w = sat_word(neg ? -q : q);
        end
      end
      OP_GT: w.cmp = a > b;
      OP_LT: w.cmp = a < b;
      OP_GE: w.cmp = a >= b;
      OP_LE: w.cmp = a <= b;
      OP_EQ: w.cmp = a == b;
      OP_NE: w.cmp = a != b;
      OP_MIN: w.value = (a < b) ? ra : rb;
      OP_MAX: w.value = (b < a) ? ra : rb;
      OP_INC: w = sat_word(a + 1);
      OP_DEC: w = sat_word(a - 1);
      OP_TOINT: w.value = $signed(ra) >>> FractionBits;
      default: ;
    endcase
    return w;
  endfunction

  always @(posedge clk_i) begin
    alu_word_t e;
    int errs;
    errs = 0;
    if (rst_ni) begin
      if (done_o) begin
        if (pending_q.size() == 0) begin
          $error("result with nothing pending: value %h", result_value_o);
          errs++;
        end else begin
          e = pending_q.pop_front();
          if (e.value !== result_value_o) begin
            $error("result_value exp %h act %h", e.value, result_value_o);
            errs++;
          end
          if (e.cmp !== compare_true_o) begin
            $error("compare_true exp %b act %b", e.cmp, compare_true_o);
            errs++;
          end
          if (e.st !== status_o) begin
            $error("status exp %0d act %0d", e.st, status_o);
            errs++;
          end
        end
      end
      if (start && !busy) pending_q.push_back(alu_predict(opcode_i, operand_a_i, operand_b_i));
    end
    fail_count <= fail_count + errs;
    pending_count <= pending_q.size();
  end

  initial fail_count = 0;
  initial pending_count = 0;

endmodule

/* bench/fixed_point_alu_top_test.sv */
// Testbench top: stimulus, clock, reset and verdict for the fixed-point ALU.
module fixed_point_alu_top_test;
  import fpalu_pkg::*;

  localparam int Latency = DefWordBits + DefFractionBits + 3;
  localparam int RandomWords = 1450;
  localparam int CycleLimit = 200000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [3:0]  opcode_i = OP_ADD;
  logic [31:0] operand_a_i = '0;
  logic [31:0] operand_b_i = '0;
  logic        done_o;
  logic [31:0] result_value_o;
  logic        compare_true_o;
  logic [1:0]  status_o;
  int          fail_count;
  int          pending_count;
  int          cycle_count = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  fixed_point_alu_top dut (.*);
  fixed_point_alu_checker checker_u (.*);

  // Watchdog on total cycles.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("FAIL fixed_point_alu_top");
      $finish;
    end
  end

  // Interesting operand values: extremes, zero, small ranges around zero, shifted and full random words.
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return 32'h0;
      3: return 32'(signed'($urandom_range(0, 4)) - 2);
      4: return 32'(signed'($urandom_range(0, 1024)) - 512);
      5: return 32'($urandom_range(0, 65535)) - 32'd32768;
      6: return $urandom() >> $urandom_range(0, 31);
      default: return $urandom();
    endcase
  endfunction

  // Offer one word and hold it until accepted; optional idle burst first.
  task automatic send_word(logic [3:0] op, logic [31:0] a, logic [31:0] b, bit gaps);
    if (gaps && $urandom_range(0, 5) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    start <= 1'b1;
    opcode_i <= op;
    operand_a_i <= a;
    operand_b_i <= b;
    @(posedge clk_i iff !busy);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: every opcode on extremes, overflow, divide by zero, rounding ties.
    for (int op = 0; op < 16; op++) begin
      send_word(op[3:0], 32'h7FFFFFFF, 32'h7FFFFFFF, 0);
    end
    send_word(OP_ADD, 32'h80000000, 32'h80000000, 0);
    send_word(OP_SUB, 32'h80000000, 32'h00000001, 0);
    send_word(OP_MUL, 32'h80000000, 32'h80000000, 0);
    send_word(OP_MUL, 32'h00000001, 32'h00000080, 0);   // tie rounds away
    send_word(OP_MUL, 32'hFFFFFFFF, 32'h00000080, 0);
    send_word(OP_DIV, 32'h00000100, 32'h00000000, 0);
    send_word(OP_DIV, 32'h80000000, 32'hFFFFFFFF, 0);
    send_word(OP_DIV, 32'h00000001, 32'h00000200, 0);   // half LSB tie
    send_word(OP_DEC, 32'h80000000, 32'h0, 0);
    send_word(OP_TOINT, 32'hFFFFFF01, 32'h0, 0);

    // Pause until every pending word has come back.
    drain();

    // Random with idle bursts, then a final stretch without gaps.
    for (int i = 0; i < RandomWords; i++) begin
      send_word(4'($urandom_range(0, 15)), pick_operand(), pick_operand(),
                i < RandomWords - 200);
    end
    drain();
    repeat (Latency + 5) @(posedge clk_i);

    if (fail_count == 0 && pending_count == 0) begin
      $display("PASS fixed_point_alu_top");
    end else begin
      $display("FAIL fixed_point_alu_top");
    end
    $finish;
  end

endmodule
